>>> hw/rtl/sitd_pkg.sv
// ----------------------------------------------------------------------------
// sitd_pkg
// Shared types and constants for the signed integer to decimal text block.
// ----------------------------------------------------------------------------
package sitd_pkg;

  localparam int DATA_W         = 32;
  localparam int NUM_DIGITS     = 10;
  localparam int BITS_PER_STAGE = 4;
  localparam int NUM_DAB_STAGES = DATA_W / BITS_PER_STAGE;
  localparam int IDX_W          = 4;
  localparam int CHAR_W         = 6;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;

  typedef logic [NUM_DIGITS-1:0][3:0] bcd_t;

  // in flight through the shift-and-add-3 stages
  typedef struct packed {
    logic              neg;
    logic [DATA_W-1:0] bin;
    bcd_t              bcd;
  } dab_t;

  // ready for character output
  typedef struct packed {
    logic             neg;
    bcd_t             bcd;
    logic [IDX_W-1:0] top;
  } txt_t;

endpackage

>>> hw/rtl/sitd_abs_stage.sv
// ----------------------------------------------------------------------------
// sitd_abs_stage
// First pipeline stage: split the input into sign and magnitude.
// ----------------------------------------------------------------------------
module sitd_abs_stage import sitd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [DATA_W-1:0] in_value,
  output logic              out_valid,
  input  logic              out_ready,
  output dab_t              out_data
);

  logic valid;
  dab_t data;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  // magnitude in unsigned arithmetic, so the most negative value stays exact
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data.neg <= in_value[DATA_W-1];
      data.bin <= in_value[DATA_W-1] ? (~in_value + 1'b1) : in_value;
      data.bcd <= '0;
    end
  end

endmodule

>>> hw/rtl/sitd_dabble_stage.sv
// ----------------------------------------------------------------------------
// sitd_dabble_stage
// One register stage of the binary to BCD conversion, several shift steps.
// ----------------------------------------------------------------------------
module sitd_dabble_stage import sitd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  dab_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output dab_t out_data
);

  logic valid;
  dab_t data;
  dab_t step_next;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_data  = data;

  // correct each digit that would overflow, then shift one binary bit in;
  // the top bit of the top digit never carries anything for a 32-bit magnitude
  always_comb begin
    step_next = in_data;
    for (int s = 0; s < BITS_PER_STAGE; s++) begin
      for (int d = 0; d < NUM_DIGITS; d++) begin
        if (step_next.bcd[d] >= 4'd5) begin
          step_next.bcd[d] = step_next.bcd[d] + 4'd3;
        end
      end
      step_next.bcd = {step_next.bcd[NUM_DIGITS-1][2:0],
                       step_next.bcd[NUM_DIGITS-2:0],
                       step_next.bin[DATA_W-1]};
      step_next.bin = {step_next.bin[DATA_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data <= step_next;
    end
  end

endmodule

>>> hw/rtl/sitd_count_stage.sv
// ----------------------------------------------------------------------------
// sitd_count_stage
// Find the most significant nonzero digit to drop leading zeros.
// ----------------------------------------------------------------------------
module sitd_count_stage import sitd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  dab_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output txt_t out_data
);

  logic             valid;
  txt_t             data;
  logic [IDX_W-1:0] top_next;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_data  = data;

  // zero keeps index 0, giving a single '0'
  always_comb begin
    top_next = '0;
    for (int i = 1; i < NUM_DIGITS; i++) begin
      if (in_data.bcd[i] != 4'd0) begin
        top_next = IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data.neg <= in_data.neg;
      data.bcd <= in_data.bcd;
      data.top <= top_next;
    end
  end

endmodule

>>> hw/rtl/sitd_serializer.sv
// ----------------------------------------------------------------------------
// sitd_serializer
// Emit sign and digits one character per beat into an output register.
// ----------------------------------------------------------------------------
module sitd_serializer import sitd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  txt_t              in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CHAR_W-1:0] out_char,
  output logic              out_last
);

  logic              busy;
  logic              neg_pend;
  logic [IDX_W-1:0]  idx;
  bcd_t              digs;
  logic              ovalid;
  logic [CHAR_W-1:0] ochar;
  logic              olast;

  logic              emit;
  logic              cur_last;
  logic [CHAR_W-1:0] cur_char;

  assign emit     = busy && (!ovalid || out_ready);
  assign cur_last = !neg_pend && (idx == '0);
  assign cur_char = neg_pend ? CHAR_MINUS : (CHAR_ZERO + {2'b00, digs[idx]});

  // take the next number in the same cycle the last character goes out
  assign in_ready = !busy || (emit && cur_last);

  assign out_valid = ovalid;
  assign out_char  = ochar;
  assign out_last  = olast;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      neg_pend <= 1'b0;
      idx      <= '0;
      ovalid   <= 1'b0;
    end else begin
      if (emit) begin
        ovalid <= 1'b1;
      end else if (out_ready) begin
        ovalid <= 1'b0;
      end
      if (in_valid && in_ready) begin
        busy     <= 1'b1;
        neg_pend <= in_data.neg;
        idx      <= in_data.top;
      end else if (emit) begin
        if (neg_pend) begin
          neg_pend <= 1'b0;
        end else begin
          idx <= idx - 1'b1;
        end
        if (cur_last) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      digs <= in_data.bcd;
    end
    if (emit) begin
      ochar <= cur_char;
      olast <= cur_last;
    end
  end

endmodule

>>> hw/rtl/signed_int_to_decimal_text_top.sv
// Throughput: one character per cycle while m_tready is high; a number has 1
// to 11 characters, and the single character port holds back the input. The
// 10-stage conversion pipeline fills up behind a busy output.
// Reset (rst, synchronous, active high) empties every stage and the output.
// ----------------------------------------------------------------------------
// signed_int_to_decimal_text_top
// Converts a signed 32-bit integer into its decimal ASCII text, one
// character per output beat, with tlast on the final character.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_text_top import sitd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] value
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [5:0] text_char, [7:6] zero
  output logic        m_tlast    // is_last
);

  // Stage chain: abs -> dabble x NUM_DAB_STAGES -> count -> serializer.
  // Every stage holds its beat until the next one has room, so a stall at
  // the output backs up cleanly without dropping or repeating anything.
  logic dab_valid [NUM_DAB_STAGES+1];
  logic dab_ready [NUM_DAB_STAGES+1];
  dab_t dab_data  [NUM_DAB_STAGES+1];

  logic txt_valid;
  logic txt_ready;
  txt_t txt_data;

  logic [CHAR_W-1:0] text_char;

  // Sign and magnitude.
  sitd_abs_stage u_abs (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_value  (s_tdata),
    .out_valid (dab_valid[0]),
    .out_ready (dab_ready[0]),
    .out_data  (dab_data[0])
  );

  // Binary to BCD, a few shift-and-add-3 steps per stage.
  for (genvar g = 0; g < NUM_DAB_STAGES; g++) begin : g_dab
    sitd_dabble_stage u_dab (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (dab_valid[g]),
      .in_ready  (dab_ready[g]),
      .in_data   (dab_data[g]),
      .out_valid (dab_valid[g+1]),
      .out_ready (dab_ready[g+1]),
      .out_data  (dab_data[g+1])
    );
  end

  // Leading-zero suppression: locate the top digit.
  sitd_count_stage u_count (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (dab_valid[NUM_DAB_STAGES]),
    .in_ready  (dab_ready[NUM_DAB_STAGES]),
    .in_data   (dab_data[NUM_DAB_STAGES]),
    .out_valid (txt_valid),
    .out_ready (txt_ready),
    .out_data  (txt_data)
  );

  // Sign, then digits from the top one down; registered output.
  sitd_serializer u_ser (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (txt_valid),
    .in_ready  (txt_ready),
    .in_data   (txt_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_char  (text_char),
    .out_last  (m_tlast)
  );

  // Pad the character up to a whole byte.
  assign m_tdata = {2'b00, text_char};

endmodule
